// ----- hw/rtl/punf_pkg.sv -----
// ----------------------------------------------------------------------------
// punf_pkg
// Shared types, codes and helpers for the PNG scanline unfilter block.
// ----------------------------------------------------------------------------
`default_nettype none

package punf_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int LINE_DEPTH  = MAX_WIDTH * 4;
    localparam int LINE_ADDR_W = $clog2(LINE_DEPTH);
    localparam int APB_ADDR_W  = 4;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COLOR_FORMAT = 2'd2;

    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    localparam logic [1:0] FMT_GRAY       = 2'd0;
    localparam logic [1:0] FMT_RGB        = 2'd1;
    localparam logic [1:0] FMT_GRAY_ALPHA = 2'd2;
    localparam logic [1:0] FMT_RGBA       = 2'd3;

    localparam logic [7:0] OPAQUE = 8'hff;

    typedef struct packed {
        logic [12:0] image_width;
        logic [15:0] image_height;
        logic [1:0]  color_format;
    } cfg_t;

    typedef enum logic [1:0] {
        KIND_IGNORE = 2'd0,
        KIND_FILTER = 2'd1,
        KIND_SAMPLE = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [7:0]             data;
        logic [LINE_ADDR_W-1:0] addr;
        logic [1:0]             k;
        logic                   has_left;
        logic                   has_up;
        logic                   row_end;
        logic                   image_end;
        logic                   emit;
        logic [1:0]             fmt;
        logic [2:0]             filt;
    } item_t;

    function automatic logic [2:0] chan_count(input logic [1:0] fmt);
        logic [2:0] n;
        case (fmt)
            FMT_GRAY:       n = 3'd1;
            FMT_RGB:        n = 3'd3;
            FMT_GRAY_ALPHA: n = 3'd2;
            default:        n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/punf_apb_regs.sv -----
// ----------------------------------------------------------------------------
// punf_apb_regs
// APB register file: image width, image height and color format.
// ----------------------------------------------------------------------------
`default_nettype none

module punf_apb_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [punf_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    output punf_pkg::cfg_t                       cfg
);

    punf_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= 13'd1;
            cfg_reg.image_height <= 16'd1;
            cfg_reg.color_format <= punf_pkg::FMT_RGBA;
        end else if (wr_en) begin
            case (reg_idx)
                punf_pkg::REG_IMAGE_WIDTH:  cfg_reg.image_width  <= pwdata[12:0];
                punf_pkg::REG_IMAGE_HEIGHT: cfg_reg.image_height <= pwdata[15:0];
                punf_pkg::REG_COLOR_FORMAT: cfg_reg.color_format <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            punf_pkg::REG_IMAGE_WIDTH:  prdata = {19'd0, cfg_reg.image_width};
            punf_pkg::REG_IMAGE_HEIGHT: prdata = {16'd0, cfg_reg.image_height};
            punf_pkg::REG_COLOR_FORMAT: prdata = {30'd0, cfg_reg.color_format};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/punf_recon.sv -----
// ----------------------------------------------------------------------------
// punf_recon
// Byte reconstruction: None, Sub, Up, Average and Paeth, modulo 256.
// ----------------------------------------------------------------------------
`default_nettype none

module punf_recon (
    input  wire logic [2:0] filt,
    input  wire logic [7:0] raw,
    input  wire logic [7:0] a,
    input  wire logic [7:0] b,
    input  wire logic [7:0] c,
    output logic      [7:0] v
);

    logic signed [9:0] p, da, db, dc;
    logic        [9:0] pa, pb, pc;
    logic        [7:0] pred;
    logic        [8:0] avg_sum;

    assign p  = signed'({2'b00, a}) + signed'({2'b00, b}) - signed'({2'b00, c});
    assign da = p - signed'({2'b00, a});
    assign db = p - signed'({2'b00, b});
    assign dc = p - signed'({2'b00, c});
    assign pa = da[9] ? 10'(-da) : 10'(da);
    assign pb = db[9] ? 10'(-db) : 10'(db);
    assign pc = dc[9] ? 10'(-dc) : 10'(dc);

    assign avg_sum = {1'b0, a} + {1'b0, b};

    always_comb begin
        case (filt)
            punf_pkg::FILT_SUB:   pred = a;
            punf_pkg::FILT_UP:    pred = b;
            punf_pkg::FILT_AVG:   pred = avg_sum[8:1];
            punf_pkg::FILT_PAETH: begin
                if (pa <= pb && pa <= pc) begin
                    pred = a;
                end else if (pb <= pc) begin
                    pred = b;
                end else begin
                    pred = c;
                end
            end
            default:              pred = 8'd0;
        endcase
    end

    assign v = raw + pred;

endmodule

`default_nettype wire

// ----- hw/rtl/png_scanline_unfilter_rgba.sv -----
// ----------------------------------------------------------------------------
// png_scanline_unfilter_rgba
// PNG scanline unfilter with prior-row line buffer and RGBA pixel output.
// ----------------------------------------------------------------------------
// Throughput: one stream byte per cycle while the output is not stalled,
//   set by the single-port-read, single-port-write line buffer and one
//   reconstruction stage. A pixel result goes through the input register,
//   then the result register, after its last byte is accepted.
// Reset: synchronous, active low; clears control state and halts until an
//   item with start_of_image; the line buffer is not cleared.
`default_nettype none

module png_scanline_unfilter_rgba (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [punf_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [7:0]                      s_data_byte,
    input  wire logic                            s_start_of_image,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [7:0]                      m_red,
    output logic      [7:0]                      m_green,
    output logic      [7:0]                      m_blue,
    output logic      [7:0]                      m_alpha,
    output logic                                 m_row_end,
    output logic                                 m_image_end,
    output logic                                 m_bad_filter
);

    localparam int AW = punf_pkg::LINE_ADDR_W;

    punf_pkg::cfg_t cfg;

    punf_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // control state, advanced at accept
    logic          halted_reg, halted_next;
    logic          awaiting_reg, awaiting_next;
    logic [AW-1:0] col_reg, col_next;
    logic [1:0]    mod3_reg, mod3_next;
    logic [15:0]   row_reg, row_next;
    logic [2:0]    filt_reg, filt_next;

    logic          s_accept;
    logic          eff_halted, eff_await;
    logic [AW-1:0] eff_col;
    logic [1:0]    eff_mod3;
    logic [15:0]   eff_row;
    logic [2:0]    ch;
    logic [1:0]    ch_m1;
    logic [12:0]   wc;
    logic [15:0]   hc;
    logic [AW:0]   stride;
    logic [1:0]    k;
    logic          has_left, row_done, img_done;
    punf_pkg::item_t item_next;

    assign s_accept   = s_valid & s_ready;
    assign eff_halted = s_start_of_image ? 1'b0 : halted_reg;
    assign eff_await  = s_start_of_image ? 1'b1 : awaiting_reg;
    assign eff_col    = s_start_of_image ? '0 : col_reg;
    assign eff_mod3   = s_start_of_image ? 2'd0 : mod3_reg;
    assign eff_row    = s_start_of_image ? 16'd0 : row_reg;

    assign ch    = punf_pkg::chan_count(cfg.color_format);
    assign ch_m1 = 2'(ch - 3'd1);
    assign wc    = (cfg.image_width == 13'd0) ? 13'd1 :
                   (cfg.image_width > 13'(punf_pkg::MAX_WIDTH)) ?
                   13'(punf_pkg::MAX_WIDTH) : cfg.image_width;
    assign hc    = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;

    always_comb begin
        case (ch)
            3'd1:    stride = (AW+1)'(wc);
            3'd2:    stride = (AW+1)'({wc, 1'b0});
            3'd3:    stride = (AW+1)'(wc) + (AW+1)'({wc, 1'b0});
            default: stride = (AW+1)'({wc, 2'b00});
        endcase
    end

    assign k        = (ch == 3'd3) ? eff_mod3 : (eff_col[1:0] & ch_m1);
    assign has_left = eff_col >= AW'(ch);
    assign row_done = ({1'b0, eff_col} + (AW+1)'(1)) >= stride;
    assign img_done = row_done && (({1'b0, eff_row} + 17'd1) >= {1'b0, hc});

    always_comb begin
        halted_next   = eff_halted;
        awaiting_next = eff_await;
        col_next      = eff_col;
        mod3_next     = eff_mod3;
        row_next      = eff_row;
        filt_next     = filt_reg;

        item_next.data      = s_data_byte;
        item_next.addr      = eff_col;
        item_next.k         = k;
        item_next.has_left  = has_left;
        item_next.has_up    = (eff_row != 16'd0);
        item_next.row_end   = row_done;
        item_next.image_end = img_done;
        item_next.emit      = (k == ch_m1);
        item_next.fmt       = cfg.color_format;
        item_next.filt      = filt_reg;

        if (eff_halted) begin
            item_next.kind = punf_pkg::KIND_IGNORE;
        end else if (eff_await) begin
            if (s_data_byte > 8'(punf_pkg::FILT_PAETH)) begin
                item_next.kind = punf_pkg::KIND_ERROR;
                halted_next    = 1'b1;
            end else begin
                item_next.kind = punf_pkg::KIND_FILTER;
                filt_next      = s_data_byte[2:0];
                awaiting_next  = 1'b0;
                col_next       = '0;
                mod3_next      = 2'd0;
            end
        end else begin
            item_next.kind = punf_pkg::KIND_SAMPLE;
            if (row_done) begin
                col_next      = '0;
                mod3_next     = 2'd0;
                awaiting_next = 1'b1;
                row_next      = eff_row + 16'd1;
                if (img_done) begin
                    halted_next = 1'b1;
                end
            end else begin
                col_next  = eff_col + AW'(1);
                mod3_next = (eff_mod3 == 2'd2) ? 2'd0 : eff_mod3 + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halted_reg   <= 1'b1;
            awaiting_reg <= 1'b1;
            col_reg      <= '0;
            mod3_reg     <= 2'd0;
            row_reg      <= 16'd0;
            filt_reg     <= punf_pkg::FILT_NONE;
        end else if (s_accept) begin
            halted_reg   <= halted_next;
            awaiting_reg <= awaiting_next;
            col_reg      <= col_next;
            mod3_reg     <= mod3_next;
            row_reg      <= row_next;
            filt_reg     <= filt_next;
        end
    end

    // reconstruction stage
    logic            a_valid_reg;
    punf_pkg::item_t a_item_reg;
    logic [7:0]      rd_data_reg;
    logic [7:0]      line_mem [punf_pkg::LINE_DEPTH];
    logic [7:0]      left_reg [4];
    logic [7:0]      upleft_reg [4];
    logic [7:0]      pix_reg [3];
    logic [7:0]      nb_a, nb_b, nb_c, v;
    logic            a_res, a_go, a_sample;
    logic            out_valid_reg;

    assign nb_a = a_item_reg.has_left ? left_reg[a_item_reg.k] : 8'd0;
    assign nb_b = a_item_reg.has_up ? rd_data_reg : 8'd0;
    assign nb_c = (a_item_reg.has_up && a_item_reg.has_left) ?
                  upleft_reg[a_item_reg.k] : 8'd0;

    punf_recon u_recon (
        .filt (a_item_reg.filt),
        .raw  (a_item_reg.data),
        .a    (nb_a),
        .b    (nb_b),
        .c    (nb_c),
        .v    (v)
    );

    assign a_sample = (a_item_reg.kind == punf_pkg::KIND_SAMPLE);
    assign a_res    = (a_item_reg.kind == punf_pkg::KIND_ERROR) ||
                      (a_sample && a_item_reg.emit);
    assign a_go     = a_valid_reg && (!a_res || !out_valid_reg || m_ready);
    assign s_ready  = !a_valid_reg || a_go;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= line_mem[item_next.addr];
        end
        if (a_go && a_sample) begin
            line_mem[a_item_reg.addr] <= v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_ready) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_item_reg <= item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_go && a_item_reg.kind == punf_pkg::KIND_FILTER) begin
            for (int i = 0; i < 4; i++) begin
                left_reg[i]   <= 8'd0;
                upleft_reg[i] <= 8'd0;
            end
        end else if (a_go && a_sample) begin
            left_reg[a_item_reg.k]   <= v;
            upleft_reg[a_item_reg.k] <= nb_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                pix_reg[i] <= 8'd0;
            end
        end else if (a_go && a_sample && a_item_reg.k != 2'd3) begin
            pix_reg[a_item_reg.k] <= v;
        end
    end

    // result register
    logic [7:0] red_next, green_next, blue_next, alpha_next;
    logic [7:0] red_reg, green_reg, blue_reg, alpha_reg;
    logic       row_end_reg, image_end_reg, bad_reg;

    always_comb begin
        case (a_item_reg.fmt)
            punf_pkg::FMT_GRAY: begin
                red_next   = v;
                green_next = v;
                blue_next  = v;
                alpha_next = punf_pkg::OPAQUE;
            end
            punf_pkg::FMT_RGB: begin
                red_next   = pix_reg[0];
                green_next = pix_reg[1];
                blue_next  = v;
                alpha_next = punf_pkg::OPAQUE;
            end
            punf_pkg::FMT_GRAY_ALPHA: begin
                red_next   = pix_reg[0];
                green_next = pix_reg[0];
                blue_next  = pix_reg[0];
                alpha_next = v;
            end
            default: begin
                red_next   = pix_reg[0];
                green_next = pix_reg[1];
                blue_next  = pix_reg[2];
                alpha_next = v;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (a_go && a_res) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_go && a_res) begin
            if (a_sample) begin
                red_reg       <= red_next;
                green_reg     <= green_next;
                blue_reg      <= blue_next;
                alpha_reg     <= alpha_next;
                row_end_reg   <= a_item_reg.row_end;
                image_end_reg <= a_item_reg.image_end;
                bad_reg       <= 1'b0;
            end else begin
                red_reg       <= 8'd0;
                green_reg     <= 8'd0;
                blue_reg      <= 8'd0;
                alpha_reg     <= 8'd0;
                row_end_reg   <= 1'b0;
                image_end_reg <= 1'b0;
                bad_reg       <= 1'b1;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_red        = red_reg;
    assign m_green      = green_reg;
    assign m_blue       = blue_reg;
    assign m_alpha      = alpha_reg;
    assign m_row_end    = row_end_reg;
    assign m_image_end  = image_end_reg;
    assign m_bad_filter = bad_reg;

    // checks
    a_err_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && a_item_reg.kind == punf_pkg::KIND_ERROR) |-> halted_reg)
        else $error("error item in flight without halt");

    a_img_end_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_image_end) |-> m_row_end)
        else $error("image end without row end");

    a_bad_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_filter) |-> (m_red == 8'd0 && m_alpha == 8'd0 &&
                                       !m_row_end && !m_image_end))
        else $error("bad filter result carries pixel data");

endmodule

`default_nettype wire

// ----- test/punf_pixel_checker.sv -----
// ----------------------------------------------------------------------------
// punf_pixel_checker
// Watches the register port and both item channels of the scanline unfilter,
// rebuilds each pixel from the accepted byte stream and compares it with the
// emitted pixel, field by field. Register reads are checked against a shadow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module punf_pixel_checker
    import punf_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    input  wire logic [31:0]           prdata,
    input  wire logic                  pready,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic [7:0]            s_data_byte,
    input  wire logic                  s_start_of_image,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic [7:0]            m_red,
    input  wire logic [7:0]            m_green,
    input  wire logic [7:0]            m_blue,
    input  wire logic [7:0]            m_alpha,
    input  wire logic                  m_row_end,
    input  wire logic                  m_image_end,
    input  wire logic                  m_bad_filter,
    output int                         fail_count,
    output int                         pending
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       row_end;
        logic       image_end;
        logic       bad_filter;
    } pixel_t;

    pixel_t      expected_px [$];
    pixel_t      want_px;

    logic [12:0] width_reg;
    logic [15:0] height_reg;
    logic [1:0]  format_reg;

    logic [7:0]  prev_line [LINE_DEPTH];
    logic [7:0]  left_px [4];
    logic [7:0]  upleft_px [4];
    logic [7:0]  held_px [3];
    int unsigned col_pos;
    int unsigned row_pos;
    logic [2:0]  row_filt;
    bit          need_filt;
    bit          stopped;
    int          errors = 0;

    function automatic int unsigned samples_per_pixel(input logic [1:0] fmt);
        case (fmt)
            FMT_GRAY:       return 1;
            FMT_RGB:        return 3;
            FMT_GRAY_ALPHA: return 2;
            default:        return 4;
        endcase
    endfunction

    function automatic logic [7:0] paeth_predict(input int a, input int b, input int c);
        int p, pa, pb, pc;
        p  = a + b - c;
        pa = (p > a) ? p - a : a - p;
        pb = (p > b) ? p - b : b - p;
        pc = (p > c) ? p - c : c - p;
        if (pa <= pb && pa <= pc) return a[7:0];
        if (pb <= pc) return b[7:0];
        return c[7:0];
    endfunction

    function automatic logic [31:0] shadow_value(input logic [APB_ADDR_W-1:0] addr);
        case (addr[APB_ADDR_W-1:2])
            REG_IMAGE_WIDTH:  return {19'd0, width_reg};
            REG_IMAGE_HEIGHT: return {16'd0, height_reg};
            REG_COLOR_FORMAT: return {30'd0, format_reg};
            default:          return 32'd0;
        endcase
    endfunction

    task automatic clear_neighbors();
        for (int i = 0; i < 4; i++) begin
            left_px[i]   = 8'd0;
            upleft_px[i] = 8'd0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic unfilter_byte(input logic [7:0] d, input logic soi);
        int unsigned ch, w, h, stride, k, a, b, c, v;
        bit          row_done, img_done;
        pixel_t      px;
        if (soi) begin
            col_pos   = 0;
            row_pos   = 0;
            need_filt = 1'b1;
            stopped   = 1'b0;
            clear_neighbors();
        end
        if (stopped) return;
        if (need_filt) begin
            if (d > 8'(FILT_PAETH)) begin
                stopped       = 1'b1;
                px            = '0;
                px.bad_filter = 1'b1;
                expected_px   = {expected_px, px};
                return;
            end
            row_filt  = d[2:0];
            need_filt = 1'b0;
            col_pos   = 0;
            clear_neighbors();
            return;
        end

        ch = samples_per_pixel(format_reg);
        w  = 32'(width_reg);
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = 32'(height_reg);
        if (h == 0) h = 1;
        stride = w * ch;
        k = col_pos % ch;
        a = (col_pos >= ch) ? 32'(left_px[k[1:0]]) : 0;
        b = (row_pos > 0) ? 32'(prev_line[col_pos[LINE_ADDR_W-1:0]]) : 0;
        c = (row_pos > 0 && col_pos >= ch) ? 32'(upleft_px[k[1:0]]) : 0;

        case (row_filt)
            FILT_SUB:   v = 32'(d) + a;
            FILT_UP:    v = 32'(d) + b;
            FILT_AVG:   v = 32'(d) + ((a + b) >> 1);
            FILT_PAETH: v = 32'(d) + 32'(paeth_predict(a, b, c));
            default:    v = 32'(d);
        endcase
        v = v & 32'hff;

        upleft_px[k[1:0]] = b[7:0];
        left_px[k[1:0]]   = v[7:0];
        prev_line[col_pos[LINE_ADDR_W-1:0]] = v[7:0];
        if (k < 3) held_px[k[1:0]] = v[7:0];

        row_done = (col_pos + 1) >= stride;
        img_done = row_done && (row_pos + 1) >= h;
        if (row_done) begin
            col_pos   = 0;
            need_filt = 1'b1;
            row_pos   = (row_pos + 1) & 32'hffff;
            if (img_done) stopped = 1'b1;
        end else begin
            col_pos = (col_pos + 1) & 32'h3fff;
        end

        if (k != ch - 1) return;
        px = '0;
        case (format_reg)
            FMT_GRAY: begin
                px.red   = v[7:0];
                px.green = v[7:0];
                px.blue  = v[7:0];
                px.alpha = OPAQUE;
            end
            FMT_RGB: begin
                px.red   = held_px[0];
                px.green = held_px[1];
                px.blue  = v[7:0];
                px.alpha = OPAQUE;
            end
            FMT_GRAY_ALPHA: begin
                px.red   = held_px[0];
                px.green = held_px[0];
                px.blue  = held_px[0];
                px.alpha = v[7:0];
            end
            default: begin
                px.red   = held_px[0];
                px.green = held_px[1];
                px.blue  = held_px[2];
                px.alpha = v[7:0];
            end
        endcase
        px.row_end   = row_done;
        px.image_end = img_done;
        expected_px  = {expected_px, px};
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = 13'd1;
            height_reg = 16'd1;
            format_reg = FMT_RGBA;
            col_pos    = 0;
            row_pos    = 0;
            row_filt   = FILT_NONE;
            need_filt  = 1'b1;
            stopped    = 1'b1;
            clear_neighbors();
            for (int i = 0; i < 3; i++) held_px[i] = 8'd0;
            expected_px.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[APB_ADDR_W-1:2])
                        REG_IMAGE_WIDTH:  width_reg  = pwdata[12:0];
                        REG_IMAGE_HEIGHT: height_reg = pwdata[15:0];
                        REG_COLOR_FORMAT: format_reg = pwdata[1:0];
                        default: ;
                    endcase
                end else begin
                    check_field("prdata", shadow_value(paddr), prdata);
                end
            end
            if (s_valid && s_ready) unfilter_byte(s_data_byte, s_start_of_image);
            if (m_valid && m_ready) begin
                if (expected_px.size() == 0) begin
                    errors++;
                    $display({"%0t: pixel with no expectation, expected none, ",
                              "actual %h %h %h %h %b%b%b"},
                             $time, m_red, m_green, m_blue, m_alpha,
                             m_row_end, m_image_end, m_bad_filter);
                end else begin
                    want_px = expected_px.pop_front();
                    check_field("red",        32'(want_px.red),   32'(m_red));
                    check_field("green",      32'(want_px.green), 32'(m_green));
                    check_field("blue",       32'(want_px.blue),  32'(m_blue));
                    check_field("alpha",      32'(want_px.alpha), 32'(m_alpha));
                    check_field("row_end",    32'(want_px.row_end),    32'(m_row_end));
                    check_field("image_end",  32'(want_px.image_end),  32'(m_image_end));
                    check_field("bad_filter", 32'(want_px.bad_filter), 32'(m_bad_filter));
                end
            end
        end
        fail_count <= errors;
        pending    <= expected_px.size();
    end

endmodule

// ----- test/png_scanline_unfilter_rgba_tb.sv -----
// ----------------------------------------------------------------------------
// png_scanline_unfilter_rgba_tb
// Drives filtered scanline byte streams into the unfilter: a directed pass over
// all filter types, the gray and RGBA formats, error and ignore cases and a
// register change inside an image, then random images in all formats with
// bursty input and a stalling output side. The pixel checker predicts and
// compares; this module decides.
`timescale 1ns / 1ps

module png_scanline_unfilter_rgba_tb;
    import punf_pkg::*;

    localparam int ITEMS       = 1800;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_t;

    logic                  aclk;
    logic                  aresetn          = 1'b0;
    logic                  psel             = 1'b0;
    logic                  penable          = 1'b0;
    logic                  pwrite           = 1'b0;
    logic [APB_ADDR_W-1:0] paddr            = '0;
    logic [31:0]           pwdata           = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_valid          = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_data_byte      = '0;
    logic                  s_start_of_image = 1'b0;
    logic                  m_valid;
    logic                  m_ready          = 1'b0;
    logic [7:0]            m_red, m_green, m_blue, m_alpha;
    logic                  m_row_end, m_image_end, m_bad_filter;
    int                    fail_count;
    int                    pending;

    int                    items_sent   = 0;
    int                    burst_left   = 0;
    int                    squeeze_req  = 0;
    int                    squeeze_done = 0;
    logic [12:0]           cur_w = 13'd1;
    logic [15:0]           cur_h = 16'd1;
    logic [1:0]            cur_fmt = FMT_RGBA;

    png_scanline_unfilter_rgba uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_data_byte(s_data_byte),
        .s_start_of_image(s_start_of_image),
        .m_valid(m_valid), .m_ready(m_ready), .m_red(m_red), .m_green(m_green),
        .m_blue(m_blue), .m_alpha(m_alpha), .m_row_end(m_row_end),
        .m_image_end(m_image_end), .m_bad_filter(m_bad_filter)
    );

    punf_pixel_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_data_byte(s_data_byte),
        .s_start_of_image(s_start_of_image),
        .m_valid(m_valid), .m_ready(m_ready), .m_red(m_red), .m_green(m_green),
        .m_blue(m_blue), .m_alpha(m_alpha), .m_row_end(m_row_end),
        .m_image_end(m_image_end), .m_bad_filter(m_bad_filter),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int row_bytes();
        int w, bpp;
        w = int'(cur_w);
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        case (cur_fmt)
            FMT_GRAY:       bpp = 1;
            FMT_RGB:        bpp = 3;
            FMT_GRAY_ALPHA: bpp = 2;
            default:        bpp = 4;
        endcase
        return w * bpp;
    endfunction

    function automatic int row_count();
        return (cur_h == 16'd0) ? 1 : int'(cur_h);
    endfunction

    function automatic logic [7:0] pick_sample();
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
                0:       return 8'h00;
                1:       return 8'hff;
                2:       return 8'h80;
                default: return 8'h7f;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic soi, input bit counts);
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        s_valid          <= 1'b1;
        s_data_byte      <= d;
        s_start_of_image <= soi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        if (counts) items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [12:0] w, input logic [15:0] h,
                              input logic [1:0] fmt);
        drain();
        apb_xfer(1'b1, REG_IMAGE_WIDTH, {19'd0, w});
        apb_xfer(1'b1, REG_IMAGE_HEIGHT, {16'd0, h});
        apb_xfer(1'b1, REG_COLOR_FORMAT, {30'd0, fmt});
        apb_xfer(1'b0, REG_IMAGE_WIDTH, 32'd0);
        apb_xfer(1'b0, REG_IMAGE_HEIGHT, 32'd0);
        apb_xfer(1'b0, REG_COLOR_FORMAT, 32'd0);
        cur_w   = w;
        cur_h   = h;
        cur_fmt = fmt;
    endtask

    // cut_at < 0: whole image; bad_row >= 0: that row gets an illegal filter
    task automatic send_image(input int cut_at, input int bad_row);
        int stride, total;
        stride = row_bytes();
        total  = row_count() * (stride + 1);
        for (int j = 0; j < total && j != cut_at; j++) begin
            if (j % (stride + 1) == 0) begin
                if (j / (stride + 1) == bad_row) begin
                    send_byte(8'($urandom_range(FILT_PAETH + 1, 255)), j == 0, 1'b1);
                    break;
                end
                send_byte(8'($urandom_range(FILT_NONE, FILT_PAETH)), j == 0, 1'b1);
            end else begin
                send_byte(pick_sample(), 1'b0, 1'b1);
            end
        end
        if (cut_at < 0 && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    endtask

    // output side
    initial begin
        rx_mode_t rx_mode;
        int       len;
        int       phase;
        phase = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (squeeze_done < squeeze_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                squeeze_done++;
            end
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            len     = $urandom_range(20, 200);
            repeat (len) begin
                case (rx_mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= (phase % 3 != 0);
                endcase
                phase++;
                @(posedge aclk);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [7:0]  gray_rows [15];
        logic [12:0] w;
        logic [15:0] h;
        int          pick;

        gray_rows = '{8'(FILT_NONE),  8'hff, 8'h00,
                      8'(FILT_SUB),   8'h01, 8'hff,
                      8'(FILT_UP),    8'h80, 8'h80,
                      8'(FILT_AVG),   8'hff, 8'hff,
                      8'(FILT_PAETH), 8'h7f, 8'h81};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // halted after reset: ignored
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);

        // zero height, single pixel, then a trailing byte
        set_config(13'd0, 16'd0, FMT_GRAY);
        send_byte(8'(FILT_SUB), 1'b1, 1'b1);
        send_byte(8'hff, 1'b0, 1'b1);
        send_byte(8'h42, 1'b0, 1'b0);

        // one row per filter type
        set_config(13'd2, 16'd5, FMT_GRAY);
        for (int i = 0; i < 15; i++) send_byte(gray_rows[i], i == 0, 1'b1);

        // illegal filter, ignored bytes, illegal filter on image start
        send_byte(8'(FILT_PAETH) + 8'd1, 1'b1, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hff, 1'b1, 1'b1);
        send_byte(8'h03, 1'b0, 1'b0);

        // width shrinks mid-row: row ends on a partial pixel
        set_config(13'd2, 16'd2, FMT_RGBA);
        send_byte(8'(FILT_NONE), 1'b1, 1'b1);
        for (int i = 1; i <= 5; i++) send_byte(8'(i * 16), 1'b0, 1'b1);
        drain();
        apb_xfer(1'b1, REG_IMAGE_WIDTH, 32'd1);
        cur_w = 13'd1;
        send_byte(8'h60, 1'b0, 1'b1);
        send_byte(8'(FILT_UP), 1'b0, 1'b1);
        for (int i = 1; i <= 4; i++) send_byte(8'(i), 1'b0, 1'b1);

        // width above the maximum, cut short, with the output held off for a while
        set_config(13'h1fff, 16'd1, FMT_GRAY);
        squeeze_req++;
        send_image(480, -1);

        // tallest image, cut short by the next image start
        set_config(13'd1, 16'hffff, FMT_RGBA);
        send_image(15, -1);

        while (items_sent < ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                pick = $urandom_range(0, 99);
                w = (pick < 5) ? 13'd0 : (pick < 85) ? 13'($urandom_range(1, 6))
                                                     : 13'($urandom_range(7, 40));
                h = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
                set_config(w, h, 2'($urandom_range(0, 3)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 75)
                send_image(-1, -1);
            else if (pick < 88)
                send_image($urandom_range(1, row_count() * (row_bytes() + 1) - 1), -1);
            else
                send_image(-1, $urandom_range(0, row_count() - 1));
        end

        drain();
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
